// File: hdl/pdc_pkg.sv
// pdc_pkg: shared types and constants of the pid dead-band controller
// payload structs, pipeline stage structs, register indexes
// no dependencies
package pdc_pkg;

  // field widths
  localparam int DATA_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int ERR_W   = 17;
  localparam int SUM_W   = 32;
  localparam int OUT_W   = 32;
  localparam int PE_W    = GAIN_W + ERR_W;          // proportional and derivative products
  localparam int PI_W    = GAIN_W + SUM_W;          // integral product
  localparam int FRAC_W  = 8;                       // Q8.8 gains
  localparam int TOTAL_W = PI_W - FRAC_W + 2;       // room for three terms

  // configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND  = CFG_IDX_W'(3);

  // saturation limits of a signed 32-bit value
  localparam logic signed [SUM_W-1:0] S32_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] S32_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // input request
  typedef struct packed {
    logic signed [DATA_W-1:0] target_value;
    logic signed [DATA_W-1:0] measured_value;
  } pdc_in_t;

  // result request
  typedef struct packed {
    logic signed [OUT_W-1:0] control_value;
    logic                    clipped;
  } pdc_out_t;

  // gains handed to the multiply stage
  typedef struct packed {
    logic signed [GAIN_W-1:0] prop_gain;
    logic signed [GAIN_W-1:0] integ_gain;
    logic signed [GAIN_W-1:0] deriv_gain;
  } pdc_gains_t;

  // error stage result
  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [SUM_W-1:0] sum;
    logic signed [ERR_W-1:0] delta;
    logic                    sum_clip;
  } pdc_err_t;

  // multiply stage result, terms already shifted down by FRAC_W
  typedef struct packed {
    logic signed [PE_W-FRAC_W-1:0] p_term;
    logic signed [PI_W-FRAC_W-1:0] i_term;
    logic signed [PE_W-FRAC_W-1:0] d_term;
    logic                          sum_clip;
  } pdc_term_t;

endpackage

// File: hdl/pdc_err_stage.sv
// pdc_err_stage: error, dead band, saturating running sum and measurement delta
// holds the controller state (error sum, previous measurement)
// depends on pdc_pkg
module pdc_err_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  pdc_pkg::pdc_in_t           in_data,
  input  logic [pdc_pkg::DATA_W-1:0] dead_band,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pdc_pkg::pdc_err_t          out_data
);
  import pdc_pkg::*;

  logic signed [ERR_W-1:0]  diff;
  logic        [ERR_W-1:0]  mag;
  logic                     in_band;
  logic signed [ERR_W-1:0]  err;
  logic signed [SUM_W:0]    sum_wide;
  logic                     sum_ovf;
  logic signed [SUM_W-1:0]  error_sum_nxt;
  logic signed [ERR_W-1:0]  delta;
  logic                     take;
  pdc_err_t                 data_nxt;

  logic                     valid_r;
  pdc_err_t                 data_r;
  logic signed [SUM_W-1:0]  error_sum_r;
  logic signed [DATA_W-1:0] prev_meas_r;

  // error with dead band
  always_comb begin
    diff    = ERR_W'(in_data.target_value) - ERR_W'(in_data.measured_value);
    mag     = diff[ERR_W-1] ? ERR_W'(-diff) : ERR_W'(diff);
    in_band = mag < ERR_W'(dead_band);
    err     = in_band ? '0 : diff;
  end

  // saturating running sum
  always_comb begin
    sum_wide = (SUM_W+1)'(error_sum_r) + (SUM_W+1)'(err);
    sum_ovf  = sum_wide[SUM_W] ^ sum_wide[SUM_W-1];
    if (sum_ovf) begin
      error_sum_nxt = sum_wide[SUM_W] ? S32_MIN : S32_MAX;
    end else begin
      error_sum_nxt = sum_wide[SUM_W-1:0];
    end
  end

  // derivative on measurement
  assign delta = ERR_W'(prev_meas_r) - ERR_W'(in_data.measured_value);

  always_comb begin
    data_nxt.err      = err;
    data_nxt.sum      = error_sum_nxt;
    data_nxt.delta    = delta;
    data_nxt.sum_clip = sum_ovf;
  end

  // handshake
  assign in_ready = !valid_r || out_ready;
  assign take     = in_valid && in_ready;

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      error_sum_r <= '0;
      prev_meas_r <= '0;
    end else begin
      if (in_ready) begin
        valid_r <= in_valid;
      end
      if (take) begin
        error_sum_r <= error_sum_nxt;
        prev_meas_r <= in_data.measured_value;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: hdl/pdc_mul_stage.sv
// pdc_mul_stage: the three gain products, each shifted right by the Q8.8 fraction
// registered stage between the error stage and the output stage
// depends on pdc_pkg
module pdc_mul_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pdc_pkg::pdc_err_t   in_data,
  input  pdc_pkg::pdc_gains_t gains,
  output logic                out_valid,
  input  logic                out_ready,
  output pdc_pkg::pdc_term_t  out_data
);
  import pdc_pkg::*;

  logic signed [PE_W-1:0] prod_p;
  logic signed [PI_W-1:0] prod_i;
  logic signed [PE_W-1:0] prod_d;
  logic                   take;
  pdc_term_t              data_nxt;

  logic                   valid_r;
  pdc_term_t              data_r;

  // exact products; floor shift is the upper bits
  always_comb begin
    prod_p = PE_W'(gains.prop_gain)  * PE_W'(in_data.err);
    prod_i = PI_W'(gains.integ_gain) * PI_W'(in_data.sum);
    prod_d = PE_W'(gains.deriv_gain) * PE_W'(in_data.delta);
    data_nxt.p_term   = prod_p[PE_W-1:FRAC_W];
    data_nxt.i_term   = prod_i[PI_W-1:FRAC_W];
    data_nxt.d_term   = prod_d[PE_W-1:FRAC_W];
    data_nxt.sum_clip = in_data.sum_clip;
  end

  // handshake
  assign in_ready = !valid_r || out_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: hdl/pdc_out_stage.sv
// pdc_out_stage: adds the three terms, saturates to signed 32 bits, output register
// drives the result channel
// depends on pdc_pkg
module pdc_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pdc_pkg::pdc_term_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pdc_pkg::pdc_out_t  out_data
);
  import pdc_pkg::*;

  logic signed [TOTAL_W-1:0] total;
  logic                      hi_ones;
  logic                      hi_zeros;
  logic                      out_ovf;
  logic                      take;
  pdc_out_t                  data_nxt;

  logic                      valid_r;
  pdc_out_t                  data_r;

  // exact sum, then clamp
  always_comb begin
    total    = TOTAL_W'(in_data.p_term) + TOTAL_W'(in_data.i_term) + TOTAL_W'(in_data.d_term);
    hi_ones  = &total[TOTAL_W-1:OUT_W-1];
    hi_zeros = ~|total[TOTAL_W-1:OUT_W-1];
    out_ovf  = !(hi_ones || hi_zeros);
    if (out_ovf) begin
      data_nxt.control_value = total[TOTAL_W-1] ? S32_MIN : S32_MAX;
    end else begin
      data_nxt.control_value = total[OUT_W-1:0];
    end
    data_nxt.clipped = out_ovf || in_data.sum_clip;
  end

  // handshake
  assign in_ready = !valid_r || out_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// File: hdl/pid_deadband_controller.sv
// pid_deadband_controller: fixed-point PID with dead band and derivative on measurement
// throughput: one request per cycle while out_stall is low; three register stages (error/sum, products, add/clamp)
// in_stall rises only when all three stages hold requests and out_stall is high
// reset (rst_n, synchronous): gains, dead band, error sum and previous measurement cleared
// depends on pdc_pkg, pdc_err_stage, pdc_mul_stage, pdc_out_stage
module pid_deadband_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pdc_pkg::pdc_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pdc_pkg::pdc_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pdc_pkg::DATA_W-1:0]    cfg_data
);
  import pdc_pkg::*;

  logic signed [GAIN_W-1:0] prop_gain_r;
  logic signed [GAIN_W-1:0] integ_gain_r;
  logic signed [GAIN_W-1:0] deriv_gain_r;
  logic        [DATA_W-1:0] dead_band_r;
  pdc_gains_t               gains;

  logic                     in_ready;
  logic                     err_valid;
  logic                     err_ready;
  pdc_err_t                 err_data;
  logic                     mul_valid;
  logic                     mul_ready;
  pdc_term_t                mul_data;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= '0;
      integ_gain_r <= '0;
      deriv_gain_r <= '0;
      dead_band_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROP_GAIN:  prop_gain_r  <= cfg_data;
        REG_INTEG_GAIN: integ_gain_r <= cfg_data;
        REG_DERIV_GAIN: deriv_gain_r <= cfg_data;
        REG_DEAD_BAND:  dead_band_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    gains.prop_gain  = prop_gain_r;
    gains.integ_gain = integ_gain_r;
    gains.deriv_gain = deriv_gain_r;
  end

  assign in_stall = !in_ready;

  // error, dead band and running sum
  pdc_err_stage u_err (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .dead_band (dead_band_r),
    .out_valid (err_valid),
    .out_ready (err_ready),
    .out_data  (err_data)
  );

  // gain products
  pdc_mul_stage u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (err_valid),
    .in_ready  (err_ready),
    .in_data   (err_data),
    .gains     (gains),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_data  (mul_data)
  );

  // add, clamp and output register
  pdc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_data   (mul_data),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_data  (out_data)
  );

  // input backpressure only when the whole pipeline is full and stalled
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && err_valid && mul_valid))
    else $error("input stalled with room in the pipeline");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // dead band write lands
  a_cfg_dead_band: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == REG_DEAD_BAND) |=> dead_band_r == $past(cfg_data))
    else $error("dead band write lost");

  // proportional gain write lands
  a_cfg_prop_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == REG_PROP_GAIN)
      |=> prop_gain_r == $signed($past(cfg_data)))
    else $error("proportional gain write lost");

endmodule

// File: test/tb_pid_deadband_controller.sv
// tb_pid_deadband_controller: self-checking bench for the pid dead-band controller
// drives samples and register writes, predicts each result and checks them in order
// depends on pdc_pkg and pid_deadband_controller
module tb_pid_deadband_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import pdc_pkg::*;

  localparam int STALL_PCT    = 26;
  localparam int HOLD_CYCLES  = 60;
  localparam int FLUSH_CYCLES = 6;     // three stages deep, plus margin
  localparam int QUIET_LIMIT  = 2000;
  localparam int REPORT_MAX   = 10;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 18;

  // integrator level where full integral gain alone exceeds the output range
  localparam longint WINDUP_SUM = 17000000;

  // indexes past the last register, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(15);

  localparam logic signed [DATA_W-1:0] S16_MAX = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] S16_MIN = 16'sh8000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  pdc_in_t              in_data;
  logic                 out_valid;
  logic                 out_stall;
  pdc_out_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  // controller state as the bench tracks it
  logic signed [GAIN_W-1:0] kp;
  logic signed [GAIN_W-1:0] ki;
  logic signed [GAIN_W-1:0] kd;
  logic [DATA_W-1:0]        band;
  logic signed [SUM_W-1:0]  acc_sum;
  logic signed [DATA_W-1:0] last_meas;

  pdc_out_t predicted_controls[$];
  int       bad_results  = 0;
  int       quiet_cycles = 0;
  bit       no_idle      = 1'b0;
  bit       hold_wanted  = 1'b0;
  int       corner_values[4] = '{-32768, 32767, 0, -1};

  // one line of the directed script: a register write or a sample
  typedef struct {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [DATA_W-1:0]    reg_value;
    pdc_in_t              sample;
    bit                   has_known;
    pdc_out_t             known;
  } script_row_t;

  script_row_t script[$];

  pid_deadband_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // signed 32-bit clamp, marks a hit
  function automatic logic signed [SUM_W-1:0] clamp32(input longint x, inout bit hit);
    if (x > longint'(S32_MAX)) begin
      hit = 1'b1;
      return S32_MAX;
    end
    if (x < longint'(S32_MIN)) begin
      hit = 1'b1;
      return S32_MIN;
    end
    return SUM_W'(x);
  endfunction

  // one control step: dead band, integrator, derivative on measurement
  function automatic pdc_out_t pid_step(input pdc_in_t s);
    longint   err;
    longint   delta;
    longint   total;
    bit       hit;
    pdc_out_t r;
    hit = 1'b0;
    err = longint'(s.target_value) - longint'(s.measured_value);
    if ((err < 0 ? -err : err) < longint'(band))
      err = 0;
    acc_sum = clamp32(longint'(acc_sum) + err, hit);
    delta = longint'(last_meas) - longint'(s.measured_value);
    last_meas = s.measured_value;
    total = ((longint'(kp) * err) >>> FRAC_W)
          + ((longint'(ki) * longint'(acc_sum)) >>> FRAC_W)
          + ((longint'(kd) * delta) >>> FRAC_W);
    r.control_value = clamp32(total, hit);
    r.clipped = hit;
    return r;
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [DATA_W-1:0] value);
    script_row_t row;
    row.is_write  = 1'b1;
    row.reg_index = idx;
    row.reg_value = value;
    row.sample    = '0;
    row.has_known = 1'b0;
    row.known     = '0;
    script.push_back(row);
  endfunction

  // target, measured, known flag, known value, known clip
  function automatic void add_sample(input int t, input int m, input bit has_known,
                                     input longint kv, input bit kc);
    script_row_t row;
    row.is_write                = 1'b0;
    row.reg_index               = '0;
    row.reg_value               = '0;
    row.sample.target_value     = DATA_W'(t);
    row.sample.measured_value   = DATA_W'(m);
    row.has_known               = has_known;
    row.known.control_value     = OUT_W'(kv);
    row.known.clipped           = kc;
    script.push_back(row);
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return '0;
      3:       return GAIN_W'(int'($urandom_range(0, 1024)) - 512);
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic void flag_mismatch(input string what, input pdc_out_t want,
                                        input pdc_out_t got);
    bad_results++;
    if (bad_results <= REPORT_MAX)
      $display("%0t: %s: expected value %0d clipped %0b, got value %0d clipped %0b",
               $time, what, want.control_value, want.clipped,
               got.control_value, got.clipped);
  endfunction

  // offer one sample, hold it until taken, then record what it should produce
  task automatic push_sample(input pdc_in_t s, input bit has_known, input pdc_out_t known);
    pdc_out_t predicted;
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    predicted = pid_step(s);
    predicted_controls.push_back(has_known ? known : predicted);
  endtask

  // stop offering and wait until every pending result is back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_controls.size() != 0)
      @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    case (idx)
      REG_PROP_GAIN:  kp = value;
      REG_INTEG_GAIN: ki = value;
      REG_DERIV_GAIN: kd = value;
      REG_DEAD_BAND:  band = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drive the integrator with full-scale error toward a goal, then past it
  task automatic ramp_sum(input longint goal, input int extra);
    pdc_in_t up;
    pdc_in_t down;
    up.target_value     = S16_MAX;
    up.measured_value   = S16_MIN;
    down.target_value   = S16_MIN;
    down.measured_value = S16_MAX;
    while (longint'(acc_sum) < goal)
      push_sample(up, 1'b0, '0);
    while (longint'(acc_sum) > goal)
      push_sample(down, 1'b0, '0);
    repeat (extra) push_sample(goal > 0 ? up : down, 1'b0, '0);
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= !no_idle && ($urandom_range(0, 99) < STALL_PCT);
    end
  end

  // compare each taken result against the oldest prediction
  always @(posedge clk) begin
    pdc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_controls.size() == 0) begin
        flag_mismatch("result with nothing pending", '0, out_data);
      end else begin
        want = predicted_controls.pop_front();
        if (out_data.control_value !== want.control_value)
          flag_mismatch("control_value", want, out_data);
        if (out_data.clipped !== want.clipped)
          flag_mismatch("clipped", want, out_data);
      end
    end
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // main sequence
  initial begin
    pdc_in_t          s;
    int               roll;
    int               e;
    int               t;
    int               m;
    int               lo;
    int               hi;
    int               setpoint;
    logic [DATA_W-1:0] band_pick;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    kp        = '0;
    ki        = '0;
    kd        = '0;
    band      = '0;
    acc_sum   = '0;
    last_meas = '0;

    // gains are zero out of reset
    add_sample(100, 30, 1, 0, 0);
    add_sample(-32768, 32767, 1, 0, 0);
    // writes past the register map are dropped
    add_write(REG_SPARE_LO, 16'h7FFF);
    add_write(REG_SPARE_HI, 16'h8000);
    add_sample(1000, 0, 1, 0, 0);
    // unity proportional gain, full-scale errors
    add_write(REG_PROP_GAIN, 16'h0100);
    add_write(REG_INTEG_GAIN, 16'h0000);
    add_write(REG_DERIV_GAIN, 16'h0000);
    add_write(REG_DEAD_BAND, 16'h0000);
    add_sample(32767, -32768, 1, 65535, 0);
    add_sample(-32768, 32767, 1, -65535, 0);
    add_write(REG_PROP_GAIN, 16'h8000);
    add_sample(32767, -32768, 1, -8388480, 0);
    // all gains at extremes
    add_write(REG_PROP_GAIN, 16'h7FFF);
    add_write(REG_INTEG_GAIN, 16'h7FFF);
    add_write(REG_DERIV_GAIN, 16'h8000);
    add_sample(0, 0, 0, 0, 0);
    add_sample(-32768, -32768, 0, 0, 0);
    add_sample(12345, -2222, 0, 0, 0);
    // dead band edges, strictly below is zeroed
    add_write(REG_PROP_GAIN, 16'h0100);
    add_write(REG_INTEG_GAIN, 16'h0000);
    add_write(REG_DERIV_GAIN, 16'h0000);
    add_write(REG_DEAD_BAND, 16'd100);
    add_sample(150, 51, 1, 0, 0);
    add_sample(150, 50, 1, 100, 0);
    add_sample(50, 150, 1, -100, 0);
    add_sample(51, 150, 1, 0, 0);
    add_write(REG_DEAD_BAND, 16'hFFFF);
    add_sample(32767, -32767, 1, 0, 0);
    add_sample(32767, -32768, 1, 65535, 0);
    // derivative on measurement, full swing and floor rounding
    add_write(REG_PROP_GAIN, 16'h0000);
    add_write(REG_DERIV_GAIN, 16'h0100);
    add_write(REG_DEAD_BAND, 16'h0000);
    add_sample(0, 32767, 1, -65535, 0);
    add_sample(0, -32768, 1, 65535, 0);
    add_write(REG_DERIV_GAIN, 16'h0001);
    add_sample(0, -32767, 1, -1, 0);

    // synchronous reset, released on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_write) begin
        settle();
        write_reg(script[i].reg_index, script[i].reg_value);
      end else begin
        push_sample(script[i].sample, script[i].has_known, script[i].known);
      end
    end

    // integrator windup until the output hits the positive rail, no idling
    settle();
    no_idle = 1'b1;
    write_reg(REG_PROP_GAIN, 16'h0200);
    write_reg(REG_INTEG_GAIN, 16'h7FFF);
    write_reg(REG_DERIV_GAIN, 16'h8000);
    write_reg(REG_DEAD_BAND, 16'h0000);
    ramp_sum(WINDUP_SUM, 4);
    // negative integral gain for the negative rail, then unwind to zero
    settle();
    write_reg(REG_INTEG_GAIN, 16'h8000);
    ramp_sum(0, 0);
    no_idle = 1'b0;

    // random phases, each with its own gains and dead band
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0:       band_pick = '0;
        1:       band_pick = 16'hFFFF;
        2:       band_pick = DATA_W'($urandom_range(0, 300));
        default: band_pick = DATA_W'($urandom);
      endcase
      write_reg(REG_PROP_GAIN, pick_gain());
      write_reg(REG_INTEG_GAIN, pick_gain());
      write_reg(REG_DERIV_GAIN, pick_gain());
      write_reg(REG_DEAD_BAND, band_pick);
      no_idle  = (ph == 2);
      setpoint = int'($urandom_range(0, 65535)) - 32768;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // long receiver hold while samples keep coming
        if (ph == 3 && k == 4)
          hold_wanted = 1'b1;
        // sender pause until the pipe is empty
        if (ph == 4 && k == PHASE_ITEMS / 2)
          settle();
        if (k % 12 == 0)
          setpoint = int'($urandom_range(0, 65535)) - 32768;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          // measurement wandering around a held setpoint
          m = int'(last_meas) + int'($urandom_range(0, 128)) - 64;
          s.target_value   = DATA_W'(setpoint);
          s.measured_value = DATA_W'(m);
        end else if (roll < 60) begin
          // error magnitude just around the dead band
          e = int'(band) + int'($urandom_range(0, 2)) - 1;
          if (e < 0)
            e = 0;
          if (e > 65535)
            e = 65535;
          if ($urandom_range(0, 1)) begin
            lo = -32768;
            hi = 32767 - e;
            m  = lo + int'($urandom_range(0, hi - lo));
            t  = m + e;
          end else begin
            lo = -32768 + e;
            hi = 32767;
            m  = lo + int'($urandom_range(0, hi - lo));
            t  = m - e;
          end
          s.target_value   = DATA_W'(t);
          s.measured_value = DATA_W'(m);
        end else if (roll < 85) begin
          s = pdc_in_t'($urandom);
        end else begin
          s.target_value   = DATA_W'(corner_values[$urandom_range(0, 3)]);
          s.measured_value = DATA_W'(corner_values[$urandom_range(0, 3)]);
        end
        push_sample(s, 1'b0, '0);
      end
    end
    no_idle = 1'b0;

    settle();
    if (bad_results == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
